// File: src/psc_pkg.sv
// Package: shared constants, counter indexes and types for the packet statistics counters.
`timescale 1ns / 1ps

package psc_pkg;

  // Counter storage width default
  localparam int unsigned CounterWidthDef = 32;

  // Register file
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 32;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_SUBNET_MASK = 2'd0,
    CFG_SHORT_LIMIT = 2'd1,
    CFG_LONG_LIMIT  = 2'd2
  } psc_cfg_idx_e;

  localparam logic [31:0] SubnetMaskRst = 32'hFFFF_FF00;
  localparam logic [15:0] ShortLimitRst = 16'd64;
  localparam logic [15:0] LongLimitRst  = 16'd1518;

  // Header codes
  localparam logic [15:0] EtherTypeIpv4   = 16'h0800;
  localparam logic [7:0]  ProtoIcmp       = 8'd1;
  localparam logic [7:0]  ProtoTcp        = 8'd6;
  localparam logic [7:0]  ProtoUdp        = 8'd17;
  localparam logic [7:0]  IcmpUnreachable = 8'd3;
  localparam logic [7:0]  IcmpRedirect    = 8'd5;
  localparam logic [31:0] AllOnes32       = 32'hFFFF_FFFF;

  // Counter slots, in result order
  localparam int unsigned NumCounters  = 12;
  localparam int unsigned IxFrames     = 0;
  localparam int unsigned IxBytes      = 1;
  localparam int unsigned IxShort      = 2;
  localparam int unsigned IxLong       = 3;
  localparam int unsigned IxIp         = 4;
  localparam int unsigned IxIpBytes    = 5;
  localparam int unsigned IxBcast      = 6;
  localparam int unsigned IxTcp        = 7;
  localparam int unsigned IxUdp        = 8;
  localparam int unsigned IxIcmp       = 9;
  localparam int unsigned IxRedirect   = 10;
  localparam int unsigned IxUnreach    = 11;

  // Per-frame classification handed from the classifier to the counter bank
  typedef struct packed {
    logic        short_hit;
    logic        long_hit;
    logic        ip_hit;
    logic        bcast_hit;
    logic        tcp_hit;
    logic        udp_hit;
    logic        icmp_hit;
    logic        redirect_hit;
    logic        unreach_hit;
    logic [15:0] payload_bytes;
  } psc_hits_t;

endpackage

// File: src/psc_classify.sv
// Classifier: decodes one registered frame header summary into counter increments.
`timescale 1ns / 1ps

module psc_classify (
  input  logic [15:0]        frame_length_i,
  input  logic [15:0]        eth_type_i,
  input  logic [3:0]         ip_header_words_i,
  input  logic [15:0]        ip_total_length_i,
  input  logic [31:0]        ip_destination_i,
  input  logic [7:0]         ip_protocol_i,
  input  logic [7:0]         icmp_kind_i,
  input  logic [31:0]        subnet_mask_i,
  input  logic [15:0]        short_limit_i,
  input  logic [15:0]        long_limit_i,
  output psc_pkg::psc_hits_t hits_o
);
  import psc_pkg::*;

  logic        is_ip;
  logic [15:0] header_bytes;
  logic        is_short;

  // Header length in bytes is words times four
  assign header_bytes = {10'd0, ip_header_words_i, 2'b00};
  assign is_ip        = (eth_type_i == EtherTypeIpv4);
  assign is_short     = (frame_length_i < short_limit_i);

  always_comb begin
    hits_o = '0;
    // Length classes: short wins when both limits are crossed
    hits_o.short_hit = is_short;
    hits_o.long_hit  = !is_short && (frame_length_i > long_limit_i);
    // IPv4 only counters
    hits_o.ip_hit    = is_ip;
    hits_o.bcast_hit = is_ip && ((ip_destination_i | subnet_mask_i) == AllOnes32);
    if (is_ip && (ip_total_length_i > header_bytes)) begin
      hits_o.payload_bytes = ip_total_length_i - header_bytes;
    end
    hits_o.tcp_hit  = is_ip && (ip_protocol_i == ProtoTcp);
    hits_o.udp_hit  = is_ip && (ip_protocol_i == ProtoUdp);
    hits_o.icmp_hit = is_ip && (ip_protocol_i == ProtoIcmp);
    hits_o.unreach_hit  = hits_o.icmp_hit && (icmp_kind_i == IcmpUnreachable);
    hits_o.redirect_hit = hits_o.icmp_hit && (icmp_kind_i == IcmpRedirect);
  end

endmodule

// File: src/packet_statistics_counters.sv
// Pipeline: an accepted transaction passes through the input register, then the counter bank
//   that doubles as result register; a stalled result channel holds it in the input register.
// Throughput: one frame per cycle while the result channel does not stall; each counter takes a single adder per cycle.
// Reset: asynchronous active low; all counters clear to zero, the registers
//   return to mask 0xFFFFFF00, short limit 64 and long limit 1518.
`timescale 1ns / 1ps

module packet_statistics_counters #(
  parameter int unsigned COUNTER_WIDTH = psc_pkg::CounterWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // register write port
  input  logic                               cfg_we_i,
  input  logic [psc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [psc_pkg::CfgDataWidth-1:0]   cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [15:0]                        frame_length_i,
  input  logic [15:0]                        eth_type_i,
  input  logic [3:0]                         ip_header_words_i,
  input  logic [15:0]                        ip_total_length_i,
  input  logic [31:0]                        ip_destination_i,
  input  logic [7:0]                         ip_protocol_i,
  input  logic [7:0]                         icmp_kind_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [31:0]                        frames_total_o,
  output logic [31:0]                        bytes_total_o,
  output logic [31:0]                        frames_short_o,
  output logic [31:0]                        frames_long_o,
  output logic [31:0]                        ip_packets_o,
  output logic [31:0]                        ip_payload_bytes_o,
  output logic [31:0]                        ip_broadcasts_o,
  output logic [31:0]                        tcp_packets_o,
  output logic [31:0]                        udp_packets_o,
  output logic [31:0]                        icmp_packets_o,
  output logic [31:0]                        icmp_redirects_o,
  output logic [31:0]                        icmp_unreachables_o
);
  import psc_pkg::*;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  // Configuration registers
  logic [31:0] subnet_mask_q;
  logic [15:0] short_limit_q;
  logic [15:0] long_limit_q;

  // Input stage
  logic        s1_valid_q;
  logic [15:0] frame_length_q;
  logic [15:0] eth_type_q;
  logic [3:0]  ip_header_words_q;
  logic [15:0] ip_total_length_q;
  logic [31:0] ip_destination_q;
  logic [7:0]  ip_protocol_q;
  logic [7:0]  icmp_kind_q;

  // Counter bank, also the result register
  logic      out_valid_q;
  cnt_t      cnt_q [NumCounters];
  cnt_t      cnt_d [NumCounters];
  cnt_t      incr  [NumCounters];

  psc_hits_t hits;
  logic      out_free;
  logic      s1_adv;
  logic      in_take;

  // Handshake: the result slot frees when empty or taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Write configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subnet_mask_q <= SubnetMaskRst;
      short_limit_q <= ShortLimitRst;
      long_limit_q  <= LongLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SUBNET_MASK: subnet_mask_q <= cfg_wdata_i;
        CFG_SHORT_LIMIT: short_limit_q <= cfg_wdata_i[15:0];
        CFG_LONG_LIMIT:  long_limit_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the header summary of an accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      frame_length_q    <= frame_length_i;
      eth_type_q        <= eth_type_i;
      ip_header_words_q <= ip_header_words_i;
      ip_total_length_q <= ip_total_length_i;
      ip_destination_q  <= ip_destination_i;
      ip_protocol_q     <= ip_protocol_i;
      icmp_kind_q       <= icmp_kind_i;
    end
  end

  psc_classify u_classify (
    .frame_length_i    (frame_length_q),
    .eth_type_i        (eth_type_q),
    .ip_header_words_i (ip_header_words_q),
    .ip_total_length_i (ip_total_length_q),
    .ip_destination_i  (ip_destination_q),
    .ip_protocol_i     (ip_protocol_q),
    .icmp_kind_i       (icmp_kind_q),
    .subnet_mask_i     (subnet_mask_q),
    .short_limit_i     (short_limit_q),
    .long_limit_i      (long_limit_q),
    .hits_o            (hits)
  );

  // Increment per counter
  always_comb begin
    incr[IxFrames]   = cnt_t'(1'b1);
    incr[IxBytes]    = cnt_t'(frame_length_q);
    incr[IxShort]    = cnt_t'(hits.short_hit);
    incr[IxLong]     = cnt_t'(hits.long_hit);
    incr[IxIp]       = cnt_t'(hits.ip_hit);
    incr[IxIpBytes]  = cnt_t'(hits.payload_bytes);
    incr[IxBcast]    = cnt_t'(hits.bcast_hit);
    incr[IxTcp]      = cnt_t'(hits.tcp_hit);
    incr[IxUdp]      = cnt_t'(hits.udp_hit);
    incr[IxIcmp]     = cnt_t'(hits.icmp_hit);
    incr[IxRedirect] = cnt_t'(hits.redirect_hit);
    incr[IxUnreach]  = cnt_t'(hits.unreach_hit);
  end

  // Add and wrap
  always_comb begin
    for (int i = 0; i < NumCounters; i++) begin
      cnt_d[i] = cnt_q[i] + incr[i];
    end
  end

  // Advance the counters and present the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        for (int i = 0; i < NumCounters; i++) begin
          cnt_q[i] <= cnt_d[i];
        end
      end
    end
  end

  // Report the low 32 bits of each counter
  assign out_valid_o         = out_valid_q;
  assign frames_total_o      = 32'(cnt_q[IxFrames]);
  assign bytes_total_o       = 32'(cnt_q[IxBytes]);
  assign frames_short_o      = 32'(cnt_q[IxShort]);
  assign frames_long_o       = 32'(cnt_q[IxLong]);
  assign ip_packets_o        = 32'(cnt_q[IxIp]);
  assign ip_payload_bytes_o  = 32'(cnt_q[IxIpBytes]);
  assign ip_broadcasts_o     = 32'(cnt_q[IxBcast]);
  assign tcp_packets_o       = 32'(cnt_q[IxTcp]);
  assign udp_packets_o       = 32'(cnt_q[IxUdp]);
  assign icmp_packets_o      = 32'(cnt_q[IxIcmp]);
  assign icmp_redirects_o    = 32'(cnt_q[IxRedirect]);
  assign icmp_unreachables_o = 32'(cnt_q[IxUnreach]);

endmodule

// File: src/psc_checker.sv
// Checker: port level properties of the packet statistics counters, bound to the top level.
`timescale 1ns / 1ps

module psc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] frames_total_o,
  input logic [31:0] frames_short_o,
  input logic [31:0] frames_long_o,
  input logic [31:0] ip_packets_o,
  input logic [31:0] tcp_packets_o,
  input logic [31:0] icmp_packets_o,
  input logic [31:0] icmp_redirects_o,
  input logic [31:0] icmp_unreachables_o
);

  // Hold a stalled result
  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frames_total_o))
    else $error("stalled result changed");

  // A frame is never both short and long
  a_short_long_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(frames_short_o) |-> $stable(frames_long_o))
    else $error("short and long counted for one frame");

  // A TCP count comes with an IPv4 count
  a_tcp_implies_ip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(tcp_packets_o) |-> !$stable(ip_packets_o))
    else $error("TCP counted without IPv4");

  // A redirect comes with an ICMP count and excludes unreachable
  a_redirect_implies_icmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(icmp_redirects_o) |-> !$stable(icmp_packets_o) && $stable(icmp_unreachables_o))
    else $error("redirect counted inconsistently");

endmodule

bind packet_statistics_counters psc_checker u_psc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .frames_total_o      (frames_total_o),
  .frames_short_o      (frames_short_o),
  .frames_long_o       (frames_long_o),
  .ip_packets_o        (ip_packets_o),
  .tcp_packets_o       (tcp_packets_o),
  .icmp_packets_o      (icmp_packets_o),
  .icmp_redirects_o    (icmp_redirects_o),
  .icmp_unreachables_o (icmp_unreachables_o)
);
